@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next clock cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lai_pkg.sv @@
`timescale 1ns / 1ps

package lai_pkg;

    localparam int SAMPLE_BITS_DEF = 11;
    localparam int W_EXTRA_BITS = 5;
    localparam int COEF_BITS = 12;
    localparam int COEF_SHIFT = 12;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_W_NOW = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_W_ONE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_W_TWO = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FBK_W_TWO = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FBK_W_THREE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_X_PREV = 3'd5;

    localparam logic signed [COEF_BITS-1:0] RST_COEF_W_NOW = 12'sd211;
    localparam logic signed [COEF_BITS-1:0] RST_COEF_W_ONE = 12'sd423;
    localparam logic signed [COEF_BITS-1:0] RST_COEF_W_TWO = 12'sd211;
    localparam logic signed [COEF_BITS-1:0] RST_FBK_W_TWO = -12'sd61;
    localparam logic signed [COEF_BITS-1:0] RST_FBK_W_THREE = -12'sd75;
    localparam logic signed [COEF_BITS-1:0] RST_COEF_X_PREV = 12'sd378;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUMW,
        ST_MUL0,
        ST_SUMY
    } lai_state_t;

    typedef struct packed {
        logic mul_en;
        logic shift_en;
    } lai_tap_ctrl_t;

endpackage

@@ sv/lai_in_if.sv @@
`timescale 1ns / 1ps

interface lai_in_if
    import lai_pkg::*;
#(
    parameter int BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic signed [BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

@@ sv/lai_out_if.sv @@
`timescale 1ns / 1ps

interface lai_out_if
    import lai_pkg::*;
#(
    parameter int BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic signed [BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

@@ sv/lai_cfg_if.sv @@
`timescale 1ns / 1ps

interface lai_cfg_if
    import lai_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [COEF_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/lookahead_iir_filter.sv @@
`timescale 1ns / 1ps

// Second-order fixed-point IIR filter, direct form II with one look-ahead
// step. One signed sample goes in per request and one saturated filtered
// sample comes out. A new request is not accepted until the last is done: after
// acceptance the block works through the tap products, the sum into
// w, the product of the current w and the output sum, one after another,
// since the w of an item feeds its own output product, and then it is ready
// again. The result sits in an output register, so the next sample is
// accepted while it waits; the block stalls only when a second result would
// have to go into a full output register. Coefficients are written through
// the configuration channel, which is always ready.
module lookahead_iir_filter
    import lai_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    lai_in_if.sink       din,
    lai_out_if.source    dout,
    lai_cfg_if.sink      cfg
);

`include "assert_macros.svh"

    localparam int W_BITS = SAMPLE_BITS + W_EXTRA_BITS;
    localparam int SUM_BITS = W_BITS + 2;
    localparam int PX_BITS = COEF_BITS + SAMPLE_BITS;
    localparam int P0_BITS = COEF_BITS + W_BITS;
    localparam logic signed [SUM_BITS-1:0] W_HI = SUM_BITS'((1 << (W_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] W_LO = -W_HI - SUM_BITS'(1);
    localparam logic signed [SUM_BITS-1:0] Y_HI =
        SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] Y_LO = -Y_HI - SUM_BITS'(1);

    lai_state_t state_reg;
    lai_state_t state_next;

    logic signed [COEF_BITS-1:0] coef_w_now_reg;
    logic signed [COEF_BITS-1:0] coef_w_one_reg;
    logic signed [COEF_BITS-1:0] coef_w_two_reg;
    logic signed [COEF_BITS-1:0] fbk_w_two_reg;
    logic signed [COEF_BITS-1:0] fbk_w_three_reg;
    logic signed [COEF_BITS-1:0] coef_x_prev_reg;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] prev_sample_reg;
    logic signed [SAMPLE_BITS-1:0] prod_x_reg;
    logic signed [W_BITS-1:0]      w_reg;
    logic signed [W_BITS-1:0]      prod_0_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;
    logic                          out_valid_reg;

    logic signed [PX_BITS-1:0]  full_x;
    logic signed [P0_BITS-1:0]  full_0;
    logic signed [SUM_BITS-1:0] w_sum;
    logic signed [SUM_BITS-1:0] y_sum;
    logic signed [W_BITS-1:0]   w_sat;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    logic          accept;
    logic          load;
    logic          in_ready;
    lai_tap_ctrl_t tap_ctrl;

    logic signed [W_BITS-1:0] tap_value [3];
    logic signed [W_BITS-1:0] tap_fb [3];
    logic signed [W_BITS-1:0] tap_ff [3];

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_w_now_reg  <= RST_COEF_W_NOW;
            coef_w_one_reg  <= RST_COEF_W_ONE;
            coef_w_two_reg  <= RST_COEF_W_TWO;
            fbk_w_two_reg   <= RST_FBK_W_TWO;
            fbk_w_three_reg <= RST_FBK_W_THREE;
            coef_x_prev_reg <= RST_COEF_X_PREV;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_COEF_W_NOW:  coef_w_now_reg  <= $signed(cfg.data);
                REG_COEF_W_ONE:  coef_w_one_reg  <= $signed(cfg.data);
                REG_COEF_W_TWO:  coef_w_two_reg  <= $signed(cfg.data);
                REG_FBK_W_TWO:   fbk_w_two_reg   <= $signed(cfg.data);
                REG_FBK_W_THREE: fbk_w_three_reg <= $signed(cfg.data);
                REG_COEF_X_PREV: coef_x_prev_reg <= $signed(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready = 1'b0;
        tap_ctrl.mul_en = 1'b0;
        tap_ctrl.shift_en = 1'b0;
        load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (din.valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                tap_ctrl.mul_en = 1'b1;
                state_next = ST_SUMW;
            end
            ST_SUMW:
            begin
                state_next = ST_MUL0;
            end
            ST_MUL0:
            begin
                state_next = ST_SUMY;
            end
            ST_SUMY:
            begin
                // hold until the output register can take the result
                if (!out_valid_reg || dout.ready)
                begin
                    load = 1'b1;
                    tap_ctrl.shift_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign din.ready = in_ready;
    assign accept = din.valid && in_ready;

    // delay line of w: three cells; cell one has only a feed-forward tap, cell three only a feedback tap, cell two both
    lai_tap_cell #(.W_BITS(W_BITS)) u_tap_one (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tap_ctrl),
        .value_in  (w_reg),
        .coef_fb   ('0),
        .coef_ff   (coef_w_one_reg),
        .value_out (tap_value[0]),
        .prod_fb   (tap_fb[0]),
        .prod_ff   (tap_ff[0])
    );

    lai_tap_cell #(.W_BITS(W_BITS)) u_tap_two (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tap_ctrl),
        .value_in  (tap_value[0]),
        .coef_fb   (fbk_w_two_reg),
        .coef_ff   (coef_w_two_reg),
        .value_out (tap_value[1]),
        .prod_fb   (tap_fb[1]),
        .prod_ff   (tap_ff[1])
    );

    lai_tap_cell #(.W_BITS(W_BITS)) u_tap_three (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tap_ctrl),
        .value_in  (tap_value[1]),
        .coef_fb   (fbk_w_three_reg),
        .coef_ff   ('0),
        .value_out (tap_value[2]),
        .prod_fb   (tap_fb[2]),
        .prod_ff   (tap_ff[2])
    );

    // look-ahead term on the previous sample
    assign full_x = PX_BITS'(coef_x_prev_reg) * PX_BITS'(prev_sample_reg);
    assign full_0 = P0_BITS'(coef_w_now_reg) * P0_BITS'(w_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
        end
        else if (load)
        begin
            prev_sample_reg <= x_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= din.sample_in;
        end
        if (tap_ctrl.mul_en)
        begin
            prod_x_reg <= $signed(full_x[COEF_SHIFT +: SAMPLE_BITS]);
        end
        if (state_reg == ST_SUMW)
        begin
            w_reg <= w_sat;
        end
        if (state_reg == ST_MUL0)
        begin
            prod_0_reg <= $signed(full_0[COEF_SHIFT +: W_BITS]);
        end
        if (load)
        begin
            out_data_reg <= y_sat;
        end
    end

    assign w_sum = SUM_BITS'(x_reg) + SUM_BITS'(prod_x_reg)
                 + SUM_BITS'(tap_fb[1]) + SUM_BITS'(tap_fb[2]);

    assign y_sum = SUM_BITS'(prod_0_reg) + SUM_BITS'(tap_ff[0]) + SUM_BITS'(tap_ff[1]);

    always_comb
    begin
        if (w_sum > W_HI)
        begin
            w_sat = W_HI[W_BITS-1:0];
        end
        else if (w_sum < W_LO)
        begin
            w_sat = W_LO[W_BITS-1:0];
        end
        else
        begin
            w_sat = w_sum[W_BITS-1:0];
        end

        if (y_sum > Y_HI)
        begin
            y_sat = Y_HI[SAMPLE_BITS-1:0];
        end
        else if (y_sum < Y_LO)
        begin
            y_sat = Y_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_sat = y_sum[SAMPLE_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign dout.valid = out_valid_reg;
    assign dout.sample_out = out_data_reg;

    `ASSERT_NEXT(a_accept_starts, accept, state_reg == ST_MUL,
        "accepted request did not start the tap products")
    `ASSERT_SAME(a_result_from_sum, $rose(out_valid_reg), $past(state_reg) == ST_SUMY,
        "result appeared without passing the output sum")
    `ASSERT_NEXT(a_line_shifts, load, tap_value[1] == $past(tap_value[0])
        && tap_value[0] == $past(w_reg), "delay line did not shift with the result")
    `ASSERT_SAME(a_no_overwrite, load, !out_valid_reg || dout.ready,
        "result written over a pending one")

endmodule

@@ sv/lai_tap_cell.sv @@
`timescale 1ns / 1ps

module lai_tap_cell
    import lai_pkg::*;
#(
    parameter int W_BITS = SAMPLE_BITS_DEF + W_EXTRA_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lai_tap_ctrl_t               ctrl,
    input  logic signed [W_BITS-1:0]    value_in,
    input  logic signed [COEF_BITS-1:0] coef_fb,
    input  logic signed [COEF_BITS-1:0] coef_ff,
    output logic signed [W_BITS-1:0]    value_out,
    output logic signed [W_BITS-1:0]    prod_fb,
    output logic signed [W_BITS-1:0]    prod_ff
);

    localparam int P_BITS = COEF_BITS + W_BITS;

    logic signed [W_BITS-1:0] value_reg;
    logic signed [W_BITS-1:0] prod_fb_reg;
    logic signed [W_BITS-1:0] prod_ff_reg;
    logic signed [P_BITS-1:0] full_fb;
    logic signed [P_BITS-1:0] full_ff;

    assign full_fb = P_BITS'(coef_fb) * P_BITS'(value_reg);
    assign full_ff = P_BITS'(coef_ff) * P_BITS'(value_reg);

    // delayed value, moves one cell down the line per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (ctrl.shift_en)
        begin
            value_reg <= value_in;
        end
    end

    // floor shift of each product is just the upper slice
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_fb_reg <= $signed(full_fb[COEF_SHIFT +: W_BITS]);
            prod_ff_reg <= $signed(full_ff[COEF_SHIFT +: W_BITS]);
        end
    end

    assign value_out = value_reg;
    assign prod_fb = prod_fb_reg;
    assign prod_ff = prod_ff_reg;

endmodule
